// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL. Each macro takes a label, the clock,
// the reset, a condition and a check, and reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The check must hold in the same cycle as the condition.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The check must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/krt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

   // Default record capacity.
   localparam int DEPTH_DEF = 64;

   // Operation codes carried by a request.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LIST   = 2'd1;
   localparam logic [1:0] OP_EDIT   = 2'd2;
   localparam logic [1:0] OP_DELETE = 2'd3;

   // Status codes carried by a response.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] record_key;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] out_key;
      logic signed [31:0] out_first;
      logic signed [31:0] out_second;
      logic               last;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] first;
      logic signed [31:0] second;
   } record_type;

   // Microprogram addresses.
   typedef logic [3:0] upc_type;
   localparam upc_type UPC_IDLE       = 4'd0;
   localparam upc_type UPC_INS_CHK    = 4'd1;
   localparam upc_type UPC_INS_SRCH   = 4'd2;
   localparam upc_type UPC_INS_APPEND = 4'd3;
   localparam upc_type UPC_EMIT_FULL  = 4'd4;
   localparam upc_type UPC_EMIT_DUP   = 4'd5;
   localparam upc_type UPC_LST_CHK    = 4'd6;
   localparam upc_type UPC_LST_OUT    = 4'd7;
   localparam upc_type UPC_EMIT_EMPTY = 4'd8;
   localparam upc_type UPC_EDT_SRCH   = 4'd9;
   localparam upc_type UPC_EDT_WR     = 4'd10;
   localparam upc_type UPC_EMIT_NF    = 4'd11;
   localparam upc_type UPC_DEL_SRCH   = 4'd12;
   localparam upc_type UPC_DEL_STEP   = 4'd13;
   localparam upc_type UPC_DEL_SHIFT  = 4'd14;
   localparam upc_type UPC_DEL_DONE   = 4'd15;

   // Jump conditions tested by a microword.
   typedef enum logic [2:0] {
      COND_NEVER  = 3'd0,
      COND_ALWAYS = 3'd1,
      COND_FULL   = 3'd2,
      COND_END    = 3'd3,
      COND_HIT    = 3'd4,
      COND_LAST   = 3'd5,
      COND_EMPTY  = 3'd6
   } cond_type;

   typedef enum logic [1:0] {
      KEY_REQ  = 2'd0,
      KEY_ZERO = 2'd1,
      KEY_RD   = 2'd2
   } key_sel_type;

   typedef enum logic {
      PAY_ZERO = 1'b0,
      PAY_RD   = 1'b1
   } pay_sel_type;

   typedef enum logic {
      LAST_ONE = 1'b0,
      LAST_CMP = 1'b1
   } last_sel_type;

   typedef enum logic {
      WA_IDX  = 1'b0,
      WA_PREV = 1'b1
   } wa_sel_type;

   typedef enum logic {
      WD_REQ   = 1'b0,
      WD_SHIFT = 1'b1
   } wd_sel_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic         accept;
      cond_type     cond1;
      upc_type      tgt1;
      cond_type     cond2;
      upc_type      tgt2;
      logic         hold;
      logic         idx_inc;
      logic         emit;
      logic [2:0]   status;
      key_sel_type  key_sel;
      pay_sel_type  pay_sel;
      last_sel_type last_sel;
      logic         mem_wr;
      wa_sel_type   wa_sel;
      wd_sel_type   wd_sel;
      logic         cnt_inc;
      logic         cnt_dec;
   } uword_type;

   // Datapath flags seen by the sequencer.
   typedef struct packed {
      logic full;
      logic at_end;
      logic hit;
      logic at_last;
      logic empty;
      logic out_free;
   } flags_type;

   // How the current step resolved.
   typedef struct packed {
      logic fire;
      logic fall;
   } step_type;

   // Entry point of the routine for each operation.
   function automatic upc_type dispatch_entry(input logic [1:0] op);
      upc_type entry;
      unique case (op)
         OP_INSERT: entry = UPC_INS_CHK;
         OP_LIST:   entry = UPC_LST_CHK;
         OP_EDIT:   entry = UPC_EDT_SRCH;
         OP_DELETE: entry = UPC_DEL_SRCH;
         default:   entry = UPC_IDLE;
      endcase
      return entry;
   endfunction

   // Control store.
   function automatic uword_type ucode_rom(input upc_type pc);
      uword_type uw;
      uw = '0;
      unique case (pc)
         UPC_IDLE: begin
            uw.accept = 1'b1;
         end
         UPC_INS_CHK: begin
            uw.cond1 = COND_FULL;
            uw.tgt1  = UPC_EMIT_FULL;
         end
         UPC_INS_SRCH: begin
            uw.cond1   = COND_END;
            uw.tgt1    = UPC_INS_APPEND;
            uw.cond2   = COND_HIT;
            uw.tgt2    = UPC_EMIT_DUP;
            uw.hold    = 1'b1;
            uw.idx_inc = 1'b1;
         end
         UPC_INS_APPEND: begin
            uw.mem_wr  = 1'b1;
            uw.wa_sel  = WA_IDX;
            uw.wd_sel  = WD_REQ;
            uw.cnt_inc = 1'b1;
            uw.emit    = 1'b1;
            uw.status  = ST_OK;
            uw.cond1   = COND_ALWAYS;
            uw.tgt1    = UPC_IDLE;
         end
         UPC_EMIT_FULL: begin
            uw.emit   = 1'b1;
            uw.status = ST_FULL;
            uw.cond1  = COND_ALWAYS;
            uw.tgt1   = UPC_IDLE;
         end
         UPC_EMIT_DUP: begin
            uw.emit   = 1'b1;
            uw.status = ST_DUP;
            uw.cond1  = COND_ALWAYS;
            uw.tgt1   = UPC_IDLE;
         end
         UPC_LST_CHK: begin
            uw.cond1 = COND_EMPTY;
            uw.tgt1  = UPC_EMIT_EMPTY;
         end
         UPC_LST_OUT: begin
            uw.emit     = 1'b1;
            uw.status   = ST_OK;
            uw.key_sel  = KEY_RD;
            uw.pay_sel  = PAY_RD;
            uw.last_sel = LAST_CMP;
            uw.cond1    = COND_LAST;
            uw.tgt1     = UPC_IDLE;
            uw.hold     = 1'b1;
            uw.idx_inc  = 1'b1;
         end
         UPC_EMIT_EMPTY: begin
            uw.emit    = 1'b1;
            uw.status  = ST_EMPTY;
            uw.key_sel = KEY_ZERO;
            uw.cond1   = COND_ALWAYS;
            uw.tgt1    = UPC_IDLE;
         end
         UPC_EDT_SRCH: begin
            uw.cond1   = COND_END;
            uw.tgt1    = UPC_EMIT_NF;
            uw.cond2   = COND_HIT;
            uw.tgt2    = UPC_EDT_WR;
            uw.hold    = 1'b1;
            uw.idx_inc = 1'b1;
         end
         UPC_EDT_WR: begin
            uw.emit    = 1'b1;
            uw.status  = ST_OK;
            uw.pay_sel = PAY_RD;
            uw.mem_wr  = 1'b1;
            uw.wa_sel  = WA_IDX;
            uw.wd_sel  = WD_REQ;
            uw.cond1   = COND_ALWAYS;
            uw.tgt1    = UPC_IDLE;
         end
         UPC_EMIT_NF: begin
            uw.emit   = 1'b1;
            uw.status = ST_NOTFOUND;
            uw.cond1  = COND_ALWAYS;
            uw.tgt1   = UPC_IDLE;
         end
         UPC_DEL_SRCH: begin
            uw.cond1   = COND_END;
            uw.tgt1    = UPC_EMIT_NF;
            uw.cond2   = COND_HIT;
            uw.tgt2    = UPC_DEL_STEP;
            uw.hold    = 1'b1;
            uw.idx_inc = 1'b1;
         end
         UPC_DEL_STEP: begin
            uw.idx_inc = 1'b1;
         end
         UPC_DEL_SHIFT: begin
            // The write on the exit cycle lands on the slot that is dropped.
            uw.mem_wr  = 1'b1;
            uw.wa_sel  = WA_PREV;
            uw.wd_sel  = WD_SHIFT;
            uw.cond1   = COND_END;
            uw.tgt1    = UPC_DEL_DONE;
            uw.hold    = 1'b1;
            uw.idx_inc = 1'b1;
         end
         UPC_DEL_DONE: begin
            uw.cnt_dec = 1'b1;
            uw.emit    = 1'b1;
            uw.status  = ST_OK;
            uw.cond1   = COND_ALWAYS;
            uw.tgt1    = UPC_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/keyed_record_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel  Direction  Handshake                Payload
// req_     in         req_valid / req_ready    req_type: op, key, two values
// rsp_     out        rsp_valid / rsp_ready    rsp_type: status, key, two values, last
//
// A microprogram walks the records one slot per cycle, unless an emitting step
// waits for the output register, through the single read port of the record
// memory; its read data is registered, so the read address is the next index.
// Reset clears the record count and the sequencer; no memory pass is needed.
// A step that emits holds while the output register is full and not taken.

module keyed_record_table import krt_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   uword_type  uw;
   step_type   st;
   flags_type  flags;

   req_type    req_ff, req_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_prev;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       wr_en;
   logic [AW-1:0] wr_addr;
   record_type wr_data;
   record_type rd_data;
   logic       emit_go;

   krt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .op        (req_data.op),
      .flags     (flags),
      .uword     (uw),
      .step      (st)
   );

   krt_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req_ready = uw.accept;

   // Flags for the jump conditions.
   always_comb begin
      flags.full     = (count_ff == CW'(DEPTH));
      flags.at_end   = (idx_ff == count_ff);
      flags.hit      = (rd_data.key == req_ff.record_key);
      flags.at_last  = ((idx_ff + CW'(1)) == count_ff);
      flags.empty    = (count_ff == '0);
      flags.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Request latch, slot index and record count.
   always_comb begin
      req_in = (req_valid && uw.accept) ? req_data : req_ff;

      idx_in = idx_ff;
      if (uw.accept) begin
         idx_in = '0;
      end else if (st.fire && st.fall && uw.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end

      count_in = count_ff;
      if (st.fire && uw.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (st.fire && uw.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Record memory write: append or edit at the index, shift to the slot below.
   always_comb begin
      idx_prev = idx_ff - CW'(1);
      wr_en    = st.fire && uw.mem_wr;
      case (uw.wa_sel)
         WA_PREV: wr_addr = idx_prev[AW-1:0];
         default: wr_addr = idx_ff[AW-1:0];
      endcase
      case (uw.wd_sel)
         WD_SHIFT: wr_data = rd_data;
         default: begin
            wr_data.key    = req_ff.record_key;
            wr_data.first  = req_ff.first_value;
            wr_data.second = req_ff.second_value;
         end
      endcase
   end

   // Output register: loaded by an emitting step, freed by a transfer.
   always_comb begin
      emit_go = st.fire && uw.emit;
      rsp_in  = rsp_ff;
      if (emit_go) begin
         rsp_in.status = uw.status;
         case (uw.key_sel)
            KEY_RD:   rsp_in.out_key = rd_data.key;
            KEY_ZERO: rsp_in.out_key = '0;
            default:  rsp_in.out_key = req_ff.record_key;
         endcase
         case (uw.pay_sel)
            PAY_RD: begin
               rsp_in.out_first  = rd_data.first;
               rsp_in.out_second = rd_data.second;
            end
            default: begin
               rsp_in.out_first  = '0;
               rsp_in.out_second = '0;
            end
         endcase
         case (uw.last_sel)
            LAST_CMP: rsp_in.last = flags.at_last;
            default:  rsp_in.last = 1'b1;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the sequencer and datapath. The index is stale while idle.
   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "record count above capacity")
   `ASSERT_IMPLY(a_idx_bound, clock, reset, !uw.accept, idx_ff <= count_ff, "slot index beyond record count")
   `ASSERT_NEXT(a_count_step, clock, reset, 1'b1, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1)) || (count_ff == $past(count_ff) - CW'(1)), "record count moved by more than one")
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "request taken while an operation runs")

endmodule

`default_nettype wire

// ===== hdl/krt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module krt_mem import krt_pkg::*; #(
   parameter int  DEPTH = DEPTH_DEF,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic       clock,
   input  wire logic       wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire record_type wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output      record_type rd_data
);

   record_type mem_ff [DEPTH];
   record_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/krt_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module krt_seq import krt_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   input  wire logic [1:0] op,
   input  wire flags_type flags,
   output      uword_type uword,
   output      step_type  step
);

   upc_type   pc_ff;
   upc_type   pc_in;
   uword_type uw;
   step_type  st;

   function automatic logic cond_true(input cond_type c, input flags_type f);
      logic res;
      case (c)
         COND_NEVER:  res = 1'b0;
         COND_ALWAYS: res = 1'b1;
         COND_FULL:   res = f.full;
         COND_END:    res = f.at_end;
         COND_HIT:    res = f.hit;
         COND_LAST:   res = f.at_last;
         COND_EMPTY:  res = f.empty;
         default:     res = 1'b0;
      endcase
      return res;
   endfunction

   assign uw = ucode_rom(pc_ff);

   // Next step: dispatch on a new request, or take the first true jump,
   // else hold or advance. A step that emits waits for the output register.
   always_comb begin
      pc_in   = pc_ff;
      st.fire = !(uw.emit && !flags.out_free);
      st.fall = 1'b0;
      if (uw.accept) begin
         if (req_valid) begin
            pc_in = dispatch_entry(op);
         end
      end else if (st.fire) begin
         if (cond_true(uw.cond1, flags)) begin
            pc_in = uw.tgt1;
         end else if (cond_true(uw.cond2, flags)) begin
            pc_in = uw.tgt2;
         end else begin
            st.fall = 1'b1;
            pc_in   = uw.hold ? pc_ff : upc_type'(pc_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UPC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign uword = uw;
   assign step  = st;

endmodule

`default_nettype wire
